// ===== hw/rtl/u8n1_pkg.sv =====
// Shared types and constants for the 8N1 UART transceiver.
// No dependencies; imported by u8n1_core and uart_8n1_transceiver.
`default_nettype none

package u8n1_pkg;

  localparam int TICK_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [TICK_W-1:0]    tick_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_BIT_TICKS    = 2'd0;
  localparam cfg_idx_t CFG_FIRST_SAMPLE = 2'd1;

  localparam tick_t BIT_TICKS_RST    = 16'd104;
  localparam tick_t FIRST_SAMPLE_RST = 16'd156;

  // One tick item; rx_line in the lowest bit
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_start;
    logic       rx_line;
  } item_t;

  // One result; tx_line in the lowest bit
  typedef struct packed {
    logic [7:0] rx_data;
    logic       rx_valid;
    logic       rx_busy;
    logic       tx_busy;
    logic       tx_line;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/uart_8n1_transceiver.sv =====
// UART 8N1 transceiver: one tick item in, one status/result item out per transfer.
// Path from input transfer to out_tdata: input reg, then result reg (via the skid entry on a stall).
// Throughput: 1 item per cycle while the skid entry is free; the core state updates once per item.
// A two-entry output register (result + skid) keeps in_tready off out_tready.
// Reset (rst_n low, synchronous): lines idle, counters cleared, bit_ticks 104,
// first_sample_ticks 156, no result pending.
`default_nettype none

module uart_8n1_transceiver #(
  parameter int DATA_BITS = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output      logic                     in_tready,
  // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
  input  wire logic [15:0]              in_tdata,
  output      logic                     out_tvalid,
  input  wire logic                     out_tready,
  // [0] tx_line, [1] tx_busy, [2] rx_busy, [3] rx_valid, [11:4] rx_data, [15:12] zero
  output      logic [15:0]              out_tdata,
  input  wire logic                     cfg_we,
  input  wire u8n1_pkg::cfg_idx_t       cfg_index,
  input  wire logic [u8n1_pkg::TICK_W-1:0] cfg_wdata
);
  import u8n1_pkg::*;

  tick_t   bit_ticks_r, first_ticks_r;
  item_t   in_d_r;
  logic    in_v_r;
  result_t out_d_r, sk_d_r, core_res;
  logic    out_v_r, sk_v_r;
  logic    step_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_ticks_r   <= BIT_TICKS_RST;
      first_ticks_r <= FIRST_SAMPLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_TICKS:    bit_ticks_r   <= cfg_wdata;
        CFG_FIRST_SAMPLE: first_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the held item steps the core whenever the skid slot is free
  assign step_en   = in_v_r && !sk_v_r;
  assign in_tready = !in_v_r || !sk_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (step_en) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_d_r <= in_tdata[9:0];
    end
  end

  u8n1_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .item        (in_d_r),
    .bit_ticks   (bit_ticks_r),
    .first_ticks (first_ticks_r),
    .res         (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (step_en) begin
      if (out_v_r && !out_tready) begin
        sk_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (!out_v_r || out_tready) begin
      out_v_r <= sk_v_r;
      sk_v_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      if (out_v_r && !out_tready) begin
        sk_d_r <= core_res;
      end else begin
        out_d_r <= core_res;
      end
    end else if ((!out_v_r || out_tready) && sk_v_r) begin
      out_d_r <= sk_d_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0000, out_d_r};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid entry held with empty output register");

  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (sk_v_r && !out_tready) |=> sk_v_r && out_v_r)
    else $error("stalled result lost");

  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_en |=> out_v_r)
    else $error("core step produced no result");

endmodule

`default_nettype wire

// ===== hw/rtl/u8n1_core.sv =====
// Receiver and transmitter state for the 8N1 UART, advanced once per tick.
// Depends on u8n1_pkg.
`default_nettype none

module u8n1_core #(
  parameter int DATA_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire u8n1_pkg::item_t  item,
  input  wire u8n1_pkg::tick_t  bit_ticks,
  input  wire u8n1_pkg::tick_t  first_ticks,
  output u8n1_pkg::result_t     res
);
  import u8n1_pkg::*;

  localparam int CntW = $clog2(DATA_BITS + 2);

  logic                 rx_active_r, rx_active_nxt;
  tick_t                rx_cnt_r, rx_cnt_nxt;
  logic [CntW-1:0]      rx_left_r, rx_left_nxt;
  logic [DATA_BITS-1:0] rx_shift_r, rx_shift_nxt;
  logic                 rx_valid_nxt;

  logic                 tx_active_r, tx_active_nxt;
  tick_t                tx_cnt_r, tx_cnt_nxt;
  logic [CntW-1:0]      tx_left_r, tx_left_nxt;
  logic [DATA_BITS:0]   tx_shift_r, tx_shift_nxt;
  logic                 tx_level_r, tx_level_nxt;

  logic [DATA_BITS-1:0] tx_data;
  logic [7:0]           rx_byte;

  generate
    if (DATA_BITS >= 8) begin : g_wide
      assign tx_data = DATA_BITS'(item.tx_byte);
      assign rx_byte = rx_shift_nxt[7:0];
    end else begin : g_narrow
      assign tx_data = item.tx_byte[DATA_BITS-1:0];
      assign rx_byte = 8'(rx_shift_nxt);
    end
  endgenerate

  always_comb begin
    rx_active_nxt = rx_active_r;
    rx_cnt_nxt    = rx_cnt_r;
    rx_left_nxt   = rx_left_r;
    rx_shift_nxt  = rx_shift_r;
    rx_valid_nxt  = 1'b0;
    // a count of 0 or 1 means the event is due this tick
    if (rx_active_r) begin
      if (rx_cnt_r > 16'd1) begin
        rx_cnt_nxt = rx_cnt_r - 16'd1;
      end else if (rx_left_r != '0) begin
        rx_shift_nxt = {item.rx_line, rx_shift_r[DATA_BITS-1:1]};
        rx_left_nxt  = rx_left_r - CntW'(1);
        rx_cnt_nxt   = bit_ticks;
      end else begin
        rx_valid_nxt  = 1'b1;
        rx_active_nxt = 1'b0;
      end
    end else if (!item.rx_line) begin
      rx_active_nxt = 1'b1;
      rx_cnt_nxt    = first_ticks;
      rx_left_nxt   = CntW'(DATA_BITS);
    end
  end

  always_comb begin
    tx_active_nxt = tx_active_r;
    tx_cnt_nxt    = tx_cnt_r;
    tx_left_nxt   = tx_left_r;
    tx_shift_nxt  = tx_shift_r;
    tx_level_nxt  = tx_level_r;
    if (tx_active_r) begin
      if (tx_cnt_r > 16'd1) begin
        tx_cnt_nxt = tx_cnt_r - 16'd1;
      end else if (tx_left_r != '0) begin
        tx_level_nxt = tx_shift_r[0];
        tx_shift_nxt = tx_shift_r >> 1;
        tx_left_nxt  = tx_left_r - CntW'(1);
        tx_cnt_nxt   = bit_ticks;
      end else begin
        tx_active_nxt = 1'b0;
        tx_level_nxt  = 1'b1;
      end
    end else if (item.tx_start) begin
      tx_active_nxt = 1'b1;
      tx_level_nxt  = 1'b0;
      tx_shift_nxt  = {1'b1, tx_data};   // stop bit rides above the data
      tx_left_nxt   = CntW'(DATA_BITS + 1);
      tx_cnt_nxt    = bit_ticks;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_active_r <= 1'b0;
      rx_cnt_r    <= '0;
      rx_left_r   <= '0;
      rx_shift_r  <= '0;
      tx_active_r <= 1'b0;
      tx_cnt_r    <= '0;
      tx_left_r   <= '0;
      tx_level_r  <= 1'b1;
    end else if (step_en) begin
      rx_active_r <= rx_active_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      rx_left_r   <= rx_left_nxt;
      rx_shift_r  <= rx_shift_nxt;
      tx_active_r <= tx_active_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      tx_left_r   <= tx_left_nxt;
      tx_level_r  <= tx_level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      tx_shift_r <= tx_shift_nxt;
    end
  end

  assign res.rx_data  = rx_byte;
  assign res.rx_valid = rx_valid_nxt;
  assign res.rx_busy  = rx_active_nxt;
  assign res.tx_busy  = tx_active_nxt;
  assign res.tx_line  = tx_level_nxt;

  a_tx_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_active_r |-> tx_level_r)
    else $error("tx line low while transmitter idle");

  a_rx_valid_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && rx_valid_nxt) |=> !rx_active_r)
    else $error("receiver still active after completion pulse");

  a_rx_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_left_r <= CntW'(DATA_BITS))
    else $error("rx bit count out of range");

  a_tx_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    tx_left_r <= CntW'(DATA_BITS + 1))
    else $error("tx bit count out of range");

endmodule

`default_nettype wire

// ===== bench/tb_uart_8n1_transceiver.sv =====
// Self-checking bench for uart_8n1_transceiver: serial frames and transmit requests
// go in as tick items, and every status item that comes out is checked against a predictor.
// Depends on u8n1_pkg and the uart_8n1_transceiver RTL.
module tb_uart_8n1_transceiver;
  import u8n1_pkg::*;

  localparam int          CHAR_BITS        = 8;
  localparam int          TX_SHIFT_BITS    = CHAR_BITS + 1;   // data plus stop bit
  localparam int          FRAME_BITS       = CHAR_BITS + 2;
  localparam int unsigned DRAIN_SLACK      = 4;               // pipeline is 2 deep
  localparam int unsigned TAIL_CYCLES      = 10;
  localparam int unsigned STALL_LIMIT      = 1000;
  localparam int unsigned MAX_REPORTS      = 40;
  localparam int unsigned MAX_FRAME_PERIOD = 16;
  localparam int unsigned LONG_HOLD        = 60;

  // Index values that decode to no register
  localparam cfg_idx_t CFG_UNUSED_2 = 2'd2;
  localparam cfg_idx_t CFG_UNUSED_3 = 2'd3;

  class uart_status_checker;
    tick_t                    bit_ticks, first_ticks;
    logic                     rx_on, tx_on, tx_lvl;
    tick_t                    rx_cnt, tx_cnt;
    logic [3:0]               rx_left, tx_left;
    logic [CHAR_BITS-1:0]     rx_sr;
    logic [TX_SHIFT_BITS-1:0] tx_sr;
    result_t                  expected_status[$];
    int unsigned              errors, checked;

    function new();
      bit_ticks   = BIT_TICKS_RST;
      first_ticks = FIRST_SAMPLE_RST;
      rx_on = 1'b0; rx_cnt = '0; rx_left = '0; rx_sr = '0;
      tx_on = 1'b0; tx_cnt = '0; tx_left = '0; tx_sr = '0;
      tx_lvl  = 1'b1;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, tick_t val);
      case (idx)
        CFG_BIT_TICKS:    bit_ticks = val;
        CFG_FIRST_SAMPLE: first_ticks = val;
        default: ;
      endcase
    endfunction

    // Down counter; a count of 0 or 1 fires on the current tick
    function bit timer_due(inout tick_t cnt);
      if (cnt > 1) begin
        cnt--;
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_tick(item_t it);
      result_t r;
      r = '0;
      // receiver looks for a start bit only if it was idle at the start of the tick
      if (rx_on) begin
        if (timer_due(rx_cnt)) begin
          if (rx_left != 0) begin
            rx_sr   = {it.rx_line, rx_sr[CHAR_BITS-1:1]};
            rx_left = rx_left - 4'd1;
            rx_cnt  = bit_ticks;
          end else begin
            r.rx_valid = 1'b1;
            rx_on      = 1'b0;
          end
        end
      end else if (!it.rx_line) begin
        rx_on   = 1'b1;
        rx_cnt  = first_ticks;
        rx_left = 4'(CHAR_BITS);
      end
      if (tx_on) begin
        if (timer_due(tx_cnt)) begin
          if (tx_left != 0) begin
            tx_lvl  = tx_sr[0];
            tx_sr   = tx_sr >> 1;
            tx_left = tx_left - 4'd1;
            tx_cnt  = bit_ticks;
          end else begin
            tx_on  = 1'b0;
            tx_lvl = 1'b1;
          end
        end
      end else if (it.tx_start) begin
        tx_on   = 1'b1;
        tx_lvl  = 1'b0;
        tx_sr   = {1'b1, it.tx_byte};
        tx_left = 4'(TX_SHIFT_BITS);
        tx_cnt  = bit_ticks;
      end
      r.tx_line = tx_lvl;
      r.tx_busy = tx_on;
      r.rx_busy = rx_on;
      r.rx_data = rx_sr;
      expected_status.push_back(r);
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch at result %0d: %s got %0h expected %0h", checked, what, got, want);
    endtask

    task check_status(result_t got);
      result_t want;
      checked++;
      if (expected_status.size() == 0) begin
        report_mismatch("result with nothing expected", got, 0);
        return;
      end
      want = expected_status.pop_front();
      if (got.tx_line !== want.tx_line) report_mismatch("tx_line", got.tx_line, want.tx_line);
      if (got.tx_busy !== want.tx_busy) report_mismatch("tx_busy", got.tx_busy, want.tx_busy);
      if (got.rx_busy !== want.rx_busy) report_mismatch("rx_busy", got.rx_busy, want.rx_busy);
      if (got.rx_valid !== want.rx_valid)
        report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
      if (got.rx_data !== want.rx_data) report_mismatch("rx_data", got.rx_data, want.rx_data);
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = CFG_BIT_TICKS;
  tick_t       cfg_wdata = '0;

  uart_status_checker status_board = new();
  int unsigned        ticks_sent = 0;
  bit                 no_idling = 1'b0;
  bit                 paused_once = 1'b0;

  uart_8n1_transceiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic tx_request();
    return $urandom_range(0, 9) == 0;
  endfunction

  task automatic send_tick(input logic line, input logic start, input logic [7:0] data);
    item_t it;
    it.rx_line  = line;
    it.tx_start = start;
    it.tx_byte  = data;
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, it};
    do @(posedge clk); while (!in_tready);
    status_board.note_tick(it);
    ticks_sent++;
  endtask

  task automatic pause_until_drained();
    in_tvalid <= 1'b0;
    while (status_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller lowers it after its last write
  task automatic write_reg(input cfg_idx_t idx, input tick_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    status_board.set_reg(idx, val);
  endtask

  task automatic load_timing(input tick_t bt, input tick_t fs);
    pause_until_drained();
    write_reg(CFG_BIT_TICKS, bt);
    write_reg(CFG_FIRST_SAMPLE, fs);
    cfg_we <= 1'b0;
  endtask

  // Start bit, data LSB first, stop bit; a cut-short frame stops after 1 to CHAR_BITS bits
  task automatic send_rx_frame(input logic [7:0] data, input int unsigned period,
                               input bit cut_short);
    logic [FRAME_BITS-1:0] frame;
    int unsigned           n_bits;
    frame  = {1'b1, data, 1'b0};
    n_bits = cut_short ? $urandom_range(1, CHAR_BITS) : FRAME_BITS;
    repeat ($urandom_range(0, 2)) send_tick(1'b1, tx_request(), 8'($urandom));
    for (int b = 0; b < n_bits; b++)
      repeat (period) send_tick(frame[b], tx_request(), 8'($urandom));
  endtask

  task automatic run_phase(input tick_t bt, input tick_t fs, input int unsigned n_ticks);
    int unsigned stop_at, period;
    stop_at = ticks_sent + n_ticks;
    period  = (bt == 0) ? 1 : bt;
    load_timing(bt, fs);
    while (ticks_sent < stop_at) begin
      if (!paused_once && ticks_sent >= 250) begin
        pause_until_drained();
        paused_once = 1'b1;
      end
      // slow bit rates get line noise only, a whole frame would take too long
      if (period > MAX_FRAME_PERIOD)
        send_tick(1'($urandom), tx_request(), 8'($urandom));
      else begin
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(1, 2 * period + 2))
               send_tick(1'($urandom), tx_request(), 8'($urandom));
          1:       send_rx_frame(8'($urandom), period, 1'b1);
          default: send_rx_frame(8'($urandom), period, 1'b0);
        endcase
      end
    end
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    repeat (3) send_tick(1'b1, 1'b0, 8'h00);

    // zero counts act as one tick; writes to unused indexes must change nothing
    pause_until_drained();
    write_reg(CFG_BIT_TICKS, 16'd0);
    write_reg(CFG_FIRST_SAMPLE, 16'd0);
    write_reg(CFG_UNUSED_2, 16'd7);
    write_reg(CFG_UNUSED_3, 16'hFFFF);
    cfg_we <= 1'b0;

    send_tick(1'b1, 1'b1, 8'hFF);           // transmitter starts
    send_tick(1'b0, 1'b1, 8'h00);           // start bit seen, request while busy dropped
    repeat (CHAR_BITS) send_tick(1'b1, 1'b0, 8'h00);
    // completion tick on both sides: low line and request are both ignored
    send_tick(1'b0, 1'b1, 8'h00);
    send_tick(1'b0, 1'b1, 8'h5A);           // new character and new frame start here
    repeat (CHAR_BITS) send_tick(1'b0, 1'b0, 8'hFF);
    send_tick(1'b1, 1'b0, 8'h00);
    send_tick(1'b1, 1'b0, 8'h00);

    run_phase(16'd4, 16'd6, 80);
    run_phase(16'd7, 16'd10, 80);
    run_phase(16'd1, 16'd1, 80);
    run_phase(16'd2, 16'd3, 80);
    no_idling = 1'b1;
    run_phase(16'd5, 16'd7, 80);
    run_phase(16'hFFFF, 16'hFFFF, 20);

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (status_board.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin : result_sink
    int unsigned hold_left;
    bit          long_hold_done;
    hold_left      = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) status_board.check_status(result_t'(out_tdata[11:0]));
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= (hold_left == 0);
      end else if (!long_hold_done && status_board.checked >= 150) begin
        // long back-pressure so the input side has to stall
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
        out_tready    <= 1'b0;
      end else if (!no_idling && $urandom_range(0, 6) == 0) begin
        hold_left   = $urandom_range(1, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

endmodule
